### hdl/fremap_pkg.sv
// ----------------------------------------------------------------------------
// fremap_pkg
// Shared widths, codes, types and the arctangent table of the fisheye remap
// coordinate generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fremap_pkg;

   localparam int COORD_BITS   = 12;
   localparam int FRAC_BITS    = 16;
   localparam int TAN_INT_BITS = 12;

   // tan and scale factor width (Q12.F)
   localparam int QW  = TAN_INT_BITS + FRAC_BITS;
   // radius width (Q12.F) and root remainder width
   localparam int LW  = COORD_BITS + FRAC_BITS;
   localparam int RMW = LW + 3;
   // angle width and rotation datapath width
   localparam int TW  = FRAC_BITS + 1;
   localparam int CW  = FRAC_BITS + 4;

   localparam int ADDR_BITS = 5;
   localparam int IDX_BITS  = ADDR_BITS - 2;

   localparam logic [63:0]   HALFPI_Q30 = 64'd1686629713;
   localparam logic [TW-1:0] HALFPI     = TW'(HALFPI_Q30 >> (30 - FRAC_BITS));
   localparam logic [QW-1:0] QMAX       = '1;
   localparam logic [QW-1:0] K_ONE      = QW'(64'd1 << FRAC_BITS);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OUTSIDE = 2'd1;
   localparam logic [1:0] ST_OFFIMG  = 2'd2;

   localparam logic [IDX_BITS-1:0] REG_LENS_RADIUS = IDX_BITS'(0);
   localparam logic [IDX_BITS-1:0] REG_OUT_WIDTH   = IDX_BITS'(1);
   localparam logic [IDX_BITS-1:0] REG_OUT_HEIGHT  = IDX_BITS'(2);
   localparam logic [IDX_BITS-1:0] REG_SRC_WIDTH   = IDX_BITS'(3);
   localparam logic [IDX_BITS-1:0] REG_SRC_HEIGHT  = IDX_BITS'(4);

   typedef struct packed {
      logic [COORD_BITS-1:0] out_row;
      logic [COORD_BITS-1:0] out_col;
   } req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] src_col;
      logic [COORD_BITS-1:0] src_row;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] lens_radius;
      logic [COORD_BITS-1:0] out_width;
      logic [COORD_BITS-1:0] out_height;
      logic [COORD_BITS-1:0] src_width;
      logic [COORD_BITS-1:0] src_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lens_radius: COORD_BITS'(800),
      out_width:   COORD_BITS'(1224),
      out_height:  COORD_BITS'(816),
      src_width:   COORD_BITS'(2484),
      src_height:  COORD_BITS'(750)
   };

   // per-word control that rides alongside the datapath
   typedef struct packed {
      logic                  valid;
      logic                  outside;
      logic                  xneg;
      logic                  yneg;
      logic [COORD_BITS-1:0] ax;
      logic [COORD_BITS-1:0] ay;
   } side_type;

   // atan(2^-i) in Q.F, floor of the Q30 value
   function automatic logic signed [CW-1:0] atan_q(input int unsigned idx);
      logic [63:0] v;
      case (idx)
         0:  v = 64'd843314856;
         1:  v = 64'd497837829;
         2:  v = 64'd263043836;
         3:  v = 64'd133525158;
         4:  v = 64'd67021686;
         5:  v = 64'd33543515;
         6:  v = 64'd16775850;
         7:  v = 64'd8388437;
         8:  v = 64'd4194282;
         9:  v = 64'd2097149;
         10: v = 64'd1048575;
         11: v = 64'd524287;
         12: v = 64'd262143;
         13: v = 64'd131071;
         14: v = 64'd65535;
         15: v = 64'd32767;
         16: v = 64'd16383;
         17: v = 64'd8191;
         18: v = 64'd4095;
         19: v = 64'd2047;
         20: v = 64'd1023;
         21: v = 64'd511;
         22: v = 64'd255;
         23: v = 64'd127;
         default: v = 64'd0;
      endcase
      return $signed(CW'(v >> (30 - FRAC_BITS)));
   endfunction

endpackage

### hdl/fremap_root.sv
// ----------------------------------------------------------------------------
// fremap_root
// Centers the pixel, squares the offsets, tests against the lens circle and
// takes the radius with a pipelined digit-by-digit square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fremap_root (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          req_valid,
   input  fremap_pkg::req_type           req_data,
   input  fremap_pkg::cfg_type           cfg,
   output fremap_pkg::side_type          side_out,
   output logic [fremap_pkg::LW-1:0]     root_out
);
   import fremap_pkg::*;

   localparam int N  = LW;
   localparam int SQ = 2 * COORD_BITS;

   logic [COORD_BITS-1:0] half_w, half_h;
   side_type              s0_in, s0_ff, s1_ff;
   logic [SQ-1:0]         sqx_ff, sqy_ff, r2_ff;
   logic [SQ:0]           sum;

   side_type       rt_side_in [0:N];
   side_type       rt_side_ff [0:N];
   logic [SQ-1:0]  rt_s_in    [0:N];
   logic [SQ-1:0]  rt_s_ff    [0:N];
   logic [RMW-1:0] rt_rem_in  [0:N];
   logic [RMW-1:0] rt_rem_ff  [0:N];
   logic [LW-1:0]  rt_root_in [0:N];
   logic [LW-1:0]  rt_root_ff [0:N];

   always_comb begin
      half_w = cfg.out_width >> 1;
      half_h = cfg.out_height >> 1;
      s0_in.valid   = req_valid;
      s0_in.outside = 1'b0;
      s0_in.xneg    = req_data.out_col < half_w;
      s0_in.ax      = s0_in.xneg ? half_w - req_data.out_col : req_data.out_col - half_w;
      s0_in.yneg    = req_data.out_row > half_h;
      s0_in.ay      = s0_in.yneg ? req_data.out_row - half_h : half_h - req_data.out_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
         s1_ff.valid <= 1'b0;
      end else if (en) begin
         s0_ff  <= s0_in;
         s1_ff  <= s0_ff;
         sqx_ff <= SQ'(s0_ff.ax) * SQ'(s0_ff.ax);
         sqy_ff <= SQ'(s0_ff.ay) * SQ'(s0_ff.ay);
         r2_ff  <= SQ'(cfg.lens_radius) * SQ'(cfg.lens_radius);
      end
   end

   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // one root bit per stage; s shifts out two bits a step and runs to zero
   always_comb begin
      logic [RMW-1:0] t;
      logic [RMW-1:0] trial;
      rt_side_in[0]         = s1_ff;
      rt_side_in[0].outside = sum >= {1'b0, r2_ff};
      rt_s_in[0]            = sum[SQ-1:0];
      rt_rem_in[0]          = '0;
      rt_root_in[0]         = '0;
      for (int k = 0; k < N; k++) begin
         rt_side_in[k+1] = rt_side_ff[k];
         rt_s_in[k+1]    = rt_s_ff[k] << 2;
         t     = {rt_rem_ff[k][RMW-3:0], rt_s_ff[k][SQ-1 -: 2]};
         trial = RMW'({rt_root_ff[k], 2'b01});
         if (t >= trial) begin
            rt_rem_in[k+1]  = t - trial;
            rt_root_in[k+1] = {rt_root_ff[k][LW-2:0], 1'b1};
         end else begin
            rt_rem_in[k+1]  = t;
            rt_root_in[k+1] = {rt_root_ff[k][LW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= N; k++) begin
         if (reset) begin
            rt_side_ff[k].valid <= 1'b0;
         end else if (en) begin
            rt_side_ff[k] <= rt_side_in[k];
            rt_s_ff[k]    <= rt_s_in[k];
            rt_rem_ff[k]  <= rt_rem_in[k];
            rt_root_ff[k] <= rt_root_in[k];
         end
      end
   end

   assign side_out = rt_side_ff[N];
   assign root_out = rt_root_ff[N];

endmodule

### hdl/fremap_angle.sv
// ----------------------------------------------------------------------------
// fremap_angle
// Normalizes the radius by the lens radius, scales to an angle in [0, pi/2)
// and runs unscaled rotation steps to get a cosine/sine pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fremap_angle (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  fremap_pkg::side_type             side_in,
   input  logic [fremap_pkg::LW-1:0]        root_in,
   input  logic [fremap_pkg::COORD_BITS-1:0] lens_radius,
   output fremap_pkg::side_type             side_out,
   output logic [fremap_pkg::TW-1:0]        theta_out,
   output logic signed [fremap_pkg::CW-1:0] cx_out,
   output logic signed [fremap_pkg::CW-1:0] cy_out
);
   import fremap_pkg::*;

   localparam int DN = FRAC_BITS;
   localparam int CN = FRAC_BITS;
   localparam int PW = FRAC_BITS + TW;
   localparam logic signed [CW-1:0] CX0 = $signed(CW'(64'd1 << FRAC_BITS));

   side_type              dv_side_in [0:DN];
   side_type              dv_side_ff [0:DN];
   logic [COORD_BITS-1:0] dv_rem_in  [0:DN];
   logic [COORD_BITS-1:0] dv_rem_ff  [0:DN];
   logic [FRAC_BITS-1:0]  dv_num_in  [0:DN];
   logic [FRAC_BITS-1:0]  dv_num_ff  [0:DN];
   logic [FRAC_BITS-1:0]  dv_q_in    [0:DN];
   logic [FRAC_BITS-1:0]  dv_q_ff    [0:DN];

   side_type      m_side_ff;
   logic [PW-1:0] prod_ff;

   side_type             cd_side_in [0:CN];
   side_type             cd_side_ff [0:CN];
   logic [TW-1:0]        cd_th_in   [0:CN];
   logic [TW-1:0]        cd_th_ff   [0:CN];
   logic signed [CW-1:0] cd_x_in    [0:CN];
   logic signed [CW-1:0] cd_x_ff    [0:CN];
   logic signed [CW-1:0] cd_y_in    [0:CN];
   logic signed [CW-1:0] cd_y_ff    [0:CN];
   logic signed [CW-1:0] cd_z_in    [0:CN];
   logic signed [CW-1:0] cd_z_ff    [0:CN];

   // restoring divide, one quotient bit per stage; integer part is below r
   always_comb begin
      logic [COORD_BITS:0] t;
      dv_side_in[0] = side_in;
      dv_rem_in[0]  = root_in[LW-1:FRAC_BITS];
      dv_num_in[0]  = root_in[FRAC_BITS-1:0];
      dv_q_in[0]    = '0;
      for (int k = 0; k < DN; k++) begin
         dv_side_in[k+1] = dv_side_ff[k];
         dv_num_in[k+1]  = dv_num_ff[k] << 1;
         t = {dv_rem_ff[k], dv_num_ff[k][FRAC_BITS-1]};
         if (t >= {1'b0, lens_radius}) begin
            dv_rem_in[k+1] = COORD_BITS'(t - {1'b0, lens_radius});
            dv_q_in[k+1]   = {dv_q_ff[k][FRAC_BITS-2:0], 1'b1};
         end else begin
            dv_rem_in[k+1] = t[COORD_BITS-1:0];
            dv_q_in[k+1]   = {dv_q_ff[k][FRAC_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= DN; k++) begin
         if (reset) begin
            dv_side_ff[k].valid <= 1'b0;
         end else if (en) begin
            dv_side_ff[k] <= dv_side_in[k];
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_num_ff[k]  <= dv_num_in[k];
            dv_q_ff[k]    <= dv_q_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_side_ff.valid <= 1'b0;
      end else if (en) begin
         m_side_ff <= dv_side_ff[DN];
         prod_ff   <= PW'(dv_q_ff[DN]) * PW'(HALFPI);
      end
   end

   always_comb begin
      logic signed [CW-1:0] sx, sy, a;
      cd_side_in[0] = m_side_ff;
      cd_th_in[0]   = prod_ff[PW-1:FRAC_BITS];
      cd_x_in[0]    = CX0;
      cd_y_in[0]    = '0;
      cd_z_in[0]    = $signed(CW'(prod_ff[PW-1:FRAC_BITS]));
      for (int k = 0; k < CN; k++) begin
         cd_side_in[k+1] = cd_side_ff[k];
         cd_th_in[k+1]   = cd_th_ff[k];
         sx = cd_y_ff[k] >>> k;
         sy = cd_x_ff[k] >>> k;
         a  = atan_q(k);
         if (cd_z_ff[k] >= 0) begin
            cd_x_in[k+1] = cd_x_ff[k] - sx;
            cd_y_in[k+1] = cd_y_ff[k] + sy;
            cd_z_in[k+1] = cd_z_ff[k] - a;
         end else begin
            cd_x_in[k+1] = cd_x_ff[k] + sx;
            cd_y_in[k+1] = cd_y_ff[k] - sy;
            cd_z_in[k+1] = cd_z_ff[k] + a;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= CN; k++) begin
         if (reset) begin
            cd_side_ff[k].valid <= 1'b0;
         end else if (en) begin
            cd_side_ff[k] <= cd_side_in[k];
            cd_th_ff[k]   <= cd_th_in[k];
            cd_x_ff[k]    <= cd_x_in[k];
            cd_y_ff[k]    <= cd_y_in[k];
            cd_z_ff[k]    <= cd_z_in[k];
         end
      end
   end

   assign side_out  = cd_side_ff[CN];
   assign theta_out = cd_th_ff[CN];
   assign cx_out    = cd_x_ff[CN];
   assign cy_out    = cd_y_ff[CN];

endmodule

### hdl/fremap_ratio.sv
// ----------------------------------------------------------------------------
// fremap_ratio
// Pipelined dividers for tan = sin/cos and k = tan/theta, both saturated to
// the Q12.F range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fremap_ratio (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  fremap_pkg::side_type             side_in,
   input  logic [fremap_pkg::TW-1:0]        theta_in,
   input  logic signed [fremap_pkg::CW-1:0] cx_in,
   input  logic signed [fremap_pkg::CW-1:0] cy_in,
   output fremap_pkg::side_type             side_out,
   output logic [fremap_pkg::QW-1:0]        k_out
);
   import fremap_pkg::*;

   localparam int N    = QW;
   localparam int UW   = CW - 1;
   localparam int SATW = UW + TAN_INT_BITS;
   localparam int KSW  = TW + TAN_INT_BITS;

   localparam logic [1:0] MODE_DIV  = 2'd0;
   localparam logic [1:0] MODE_MAX  = 2'd1;
   localparam logic [1:0] MODE_ZERO = 2'd2;
   localparam logic [1:0] MODE_ONE  = 2'd3;

   logic [UW-1:0] cxu, cyu;
   logic [QW-1:0] tanq;

   side_type      tn_side_in [0:N];
   side_type      tn_side_ff [0:N];
   logic [1:0]    tn_mode_in [0:N];
   logic [1:0]    tn_mode_ff [0:N];
   logic [TW-1:0] tn_th_in   [0:N];
   logic [TW-1:0] tn_th_ff   [0:N];
   logic [UW-1:0] tn_div_in  [0:N];
   logic [UW-1:0] tn_div_ff  [0:N];
   logic [CW-1:0] tn_rem_in  [0:N];
   logic [CW-1:0] tn_rem_ff  [0:N];
   logic [QW-1:0] tn_num_in  [0:N];
   logic [QW-1:0] tn_num_ff  [0:N];
   logic [QW-1:0] tn_q_in    [0:N];
   logic [QW-1:0] tn_q_ff    [0:N];

   side_type      km_side_in [0:N];
   side_type      km_side_ff [0:N];
   logic [1:0]    km_mode_in [0:N];
   logic [1:0]    km_mode_ff [0:N];
   logic [TW-1:0] km_th_in   [0:N];
   logic [TW-1:0] km_th_ff   [0:N];
   logic [TW-1:0] km_rem_in  [0:N];
   logic [TW-1:0] km_rem_ff  [0:N];
   logic [QW-1:0] km_num_in  [0:N];
   logic [QW-1:0] km_num_ff  [0:N];
   logic [QW-1:0] km_q_in    [0:N];
   logic [QW-1:0] km_q_ff    [0:N];

   assign cxu = cx_in[UW-1:0];
   assign cyu = cy_in[UW-1:0];

   // tan: quotient fits 28 bits unless sin >= cos * 2^12, which saturates
   always_comb begin
      logic [CW:0] t;
      tn_side_in[0] = side_in;
      tn_th_in[0]   = theta_in;
      tn_div_in[0]  = cxu;
      tn_rem_in[0]  = CW'(cyu >> TAN_INT_BITS);
      tn_num_in[0]  = {cyu[TAN_INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      tn_q_in[0]    = '0;
      if (cx_in <= 0) begin
         tn_mode_in[0] = MODE_MAX;
      end else if (cy_in <= 0) begin
         tn_mode_in[0] = MODE_ZERO;
      end else if (SATW'(cyu) >= (SATW'(cxu) << TAN_INT_BITS)) begin
         tn_mode_in[0] = MODE_MAX;
      end else begin
         tn_mode_in[0] = MODE_DIV;
      end
      for (int k = 0; k < N; k++) begin
         tn_side_in[k+1] = tn_side_ff[k];
         tn_mode_in[k+1] = tn_mode_ff[k];
         tn_th_in[k+1]   = tn_th_ff[k];
         tn_div_in[k+1]  = tn_div_ff[k];
         tn_num_in[k+1]  = tn_num_ff[k] << 1;
         t = {tn_rem_ff[k], tn_num_ff[k][QW-1]};
         if (t >= {2'b00, tn_div_ff[k]}) begin
            tn_rem_in[k+1] = CW'(t - {2'b00, tn_div_ff[k]});
            tn_q_in[k+1]   = {tn_q_ff[k][QW-2:0], 1'b1};
         end else begin
            tn_rem_in[k+1] = t[CW-1:0];
            tn_q_in[k+1]   = {tn_q_ff[k][QW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      case (tn_mode_ff[N])
         MODE_MAX:  tanq = QMAX;
         MODE_ZERO: tanq = '0;
         default:   tanq = tn_q_ff[N];
      endcase
   end

   // k: zero angle means k = 1.0, tan >= theta * 2^12 saturates
   always_comb begin
      logic [TW:0] t;
      km_side_in[0] = tn_side_ff[N];
      km_th_in[0]   = tn_th_ff[N];
      km_rem_in[0]  = TW'(tanq >> TAN_INT_BITS);
      km_num_in[0]  = {tanq[TAN_INT_BITS-1:0], {FRAC_BITS{1'b0}}};
      km_q_in[0]    = '0;
      if (tn_th_ff[N] == '0) begin
         km_mode_in[0] = MODE_ONE;
      end else if (KSW'(tanq) >= (KSW'(tn_th_ff[N]) << TAN_INT_BITS)) begin
         km_mode_in[0] = MODE_MAX;
      end else begin
         km_mode_in[0] = MODE_DIV;
      end
      for (int k = 0; k < N; k++) begin
         km_side_in[k+1] = km_side_ff[k];
         km_mode_in[k+1] = km_mode_ff[k];
         km_th_in[k+1]   = km_th_ff[k];
         km_num_in[k+1]  = km_num_ff[k] << 1;
         t = {km_rem_ff[k], km_num_ff[k][QW-1]};
         if (t >= {1'b0, km_th_ff[k]}) begin
            km_rem_in[k+1] = TW'(t - {1'b0, km_th_ff[k]});
            km_q_in[k+1]   = {km_q_ff[k][QW-2:0], 1'b1};
         end else begin
            km_rem_in[k+1] = t[TW-1:0];
            km_q_in[k+1]   = {km_q_ff[k][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= N; k++) begin
         if (reset) begin
            tn_side_ff[k].valid <= 1'b0;
            km_side_ff[k].valid <= 1'b0;
         end else if (en) begin
            tn_side_ff[k] <= tn_side_in[k];
            tn_mode_ff[k] <= tn_mode_in[k];
            tn_th_ff[k]   <= tn_th_in[k];
            tn_div_ff[k]  <= tn_div_in[k];
            tn_rem_ff[k]  <= tn_rem_in[k];
            tn_num_ff[k]  <= tn_num_in[k];
            tn_q_ff[k]    <= tn_q_in[k];
            km_side_ff[k] <= km_side_in[k];
            km_mode_ff[k] <= km_mode_in[k];
            km_th_ff[k]   <= km_th_in[k];
            km_rem_ff[k]  <= km_rem_in[k];
            km_num_ff[k]  <= km_num_in[k];
            km_q_ff[k]    <= km_q_in[k];
         end
      end
   end

   assign side_out = km_side_ff[N];

   always_comb begin
      case (km_mode_ff[N])
         MODE_ONE: k_out = K_ONE;
         MODE_MAX: k_out = QMAX;
         default:  k_out = km_q_ff[N];
      endcase
   end

endmodule

### hdl/fremap_out.sv
// ----------------------------------------------------------------------------
// fremap_out
// Scales the offsets, adds the source center, truncates, checks the source
// bounds and holds the result word in an output register with a skid stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fremap_out (
   input  logic                              clock,
   input  logic                              reset,
   input  fremap_pkg::side_type              side_in,
   input  logic [fremap_pkg::QW-1:0]         k_in,
   input  logic [fremap_pkg::COORD_BITS-1:0] src_width,
   input  logic [fremap_pkg::COORD_BITS-1:0] src_height,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output fremap_pkg::rsp_type               rsp_data,
   output logic                              en
);
   import fremap_pkg::*;

   localparam int MW  = COORD_BITS + QW;
   localparam int VW  = MW + 2;
   localparam int TRW = VW - FRAC_BITS;

   side_type      a_side_ff;
   logic [MW-1:0] dxm_ff, dym_ff;

   logic signed [VW-1:0]  base_c, base_r, vc, vr;
   logic [VW-1:0]         abs_c, abs_r;
   logic signed [TRW-1:0] sh_c, sh_r, tc_in, tr_in;

   side_type              b_side_ff;
   logic signed [TRW-1:0] tc_ff, tr_ff;

   logic signed [TRW-1:0] sw_s, shgt_s;
   rsp_type               res;

   logic    out_v_ff, skid_v_ff;
   rsp_type out_ff, skid_ff;
   logic    out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_side_ff.valid <= 1'b0;
         b_side_ff.valid <= 1'b0;
      end else if (en) begin
         a_side_ff <= side_in;
         dxm_ff    <= MW'(side_in.ax) * MW'(k_in);
         dym_ff    <= MW'(side_in.ay) * MW'(k_in);
         b_side_ff <= a_side_ff;
         tc_ff     <= tc_in;
         tr_ff     <= tr_in;
      end
   end

   // row axis points down in the source, so dy enters with the opposite sign
   always_comb begin
      base_c = $signed(VW'(src_width >> 1) << FRAC_BITS);
      base_r = $signed(VW'(src_height >> 1) << FRAC_BITS);
      vc = a_side_ff.xneg ? base_c - $signed(VW'(dxm_ff)) : base_c + $signed(VW'(dxm_ff));
      vr = a_side_ff.yneg ? base_r + $signed(VW'(dym_ff)) : base_r - $signed(VW'(dym_ff));
      abs_c = vc[VW-1] ? VW'(-vc) : VW'(vc);
      abs_r = vr[VW-1] ? VW'(-vr) : VW'(vr);
      sh_c  = $signed(abs_c[VW-1:FRAC_BITS]);
      sh_r  = $signed(abs_r[VW-1:FRAC_BITS]);
      tc_in = vc[VW-1] ? -sh_c : sh_c;
      tr_in = vr[VW-1] ? -sh_r : sh_r;
   end

   always_comb begin
      sw_s   = $signed(TRW'(src_width));
      shgt_s = $signed(TRW'(src_height));
      res.src_col = '0;
      res.src_row = '0;
      if (b_side_ff.outside) begin
         res.status = ST_OUTSIDE;
      end else if (tc_ff < 0 || tc_ff >= sw_s || tr_ff < 0 || tr_ff >= shgt_s) begin
         res.status = ST_OFFIMG;
      end else begin
         res.status  = ST_OK;
         res.src_col = tc_ff[COORD_BITS-1:0];
         res.src_row = tr_ff[COORD_BITS-1:0];
      end
   end

   // the pipe only moves while the skid stage is empty
   assign en       = !skid_v_ff;
   assign out_free = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (en && b_side_ff.valid) begin
         if (out_free) begin
            out_ff   <= res;
            out_v_ff <= 1'b1;
         end else begin
            skid_ff   <= res;
            skid_v_ff <= 1'b1;
         end
      end else if (skid_v_ff && out_free) begin
         out_ff    <= skid_ff;
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

### hdl/fisheye_remap_coordinate_gen.sv
// ----------------------------------------------------------------------------
// fisheye_remap_coordinate_gen
// Throughput: one word per cycle while the skid stage is empty; every stage
// of the root, divide and rotation pipes takes one bit or one step per cycle.
// Reset: valid bits and handshake state cleared, registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fisheye_remap_coordinate_gen (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  fremap_pkg::req_type              req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output fremap_pkg::rsp_type              rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fremap_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import fremap_pkg::*;

   cfg_type                 cfg_ff, cfg_in;
   logic [IDX_BITS-1:0]     idx;
   logic [COORD_BITS-1:0]   wval;
   logic                    en;

   side_type             root_side, ang_side, rat_side;
   logic [LW-1:0]        root;
   logic [TW-1:0]        theta;
   logic signed [CW-1:0] cx, cy;
   logic [QW-1:0]        k;

   assign idx        = csr_paddr[ADDR_BITS-1:2];
   assign wval       = csr_pwdata[COORD_BITS-1:0];
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            REG_LENS_RADIUS: cfg_in.lens_radius = wval;
            REG_OUT_WIDTH:   cfg_in.out_width   = wval;
            REG_OUT_HEIGHT:  cfg_in.out_height  = wval;
            REG_SRC_WIDTH:   cfg_in.src_width   = wval;
            REG_SRC_HEIGHT:  cfg_in.src_height  = wval;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_LENS_RADIUS: csr_prdata = 32'(cfg_ff.lens_radius);
         REG_OUT_WIDTH:   csr_prdata = 32'(cfg_ff.out_width);
         REG_OUT_HEIGHT:  csr_prdata = 32'(cfg_ff.out_height);
         REG_SRC_WIDTH:   csr_prdata = 32'(cfg_ff.src_width);
         REG_SRC_HEIGHT:  csr_prdata = 32'(cfg_ff.src_height);
         default:         csr_prdata = '0;
      endcase
   end

   assign req_stall = !en;

   fremap_root u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .req_valid (req_valid),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .side_out  (root_side),
      .root_out  (root)
   );

   fremap_angle u_angle (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .side_in     (root_side),
      .root_in     (root),
      .lens_radius (cfg_ff.lens_radius),
      .side_out    (ang_side),
      .theta_out   (theta),
      .cx_out      (cx),
      .cy_out      (cy)
   );

   fremap_ratio u_ratio (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .side_in  (ang_side),
      .theta_in (theta),
      .cx_in    (cx),
      .cy_in    (cy),
      .side_out (rat_side),
      .k_out    (k)
   );

   fremap_out u_out (
      .clock      (clock),
      .reset      (reset),
      .side_in    (rat_side),
      .k_in       (k),
      .src_width  (cfg_ff.src_width),
      .src_height (cfg_ff.src_height),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .en         (en)
   );

`ifndef SYNTH
   // skid stage fills only behind a held output word
   a_skid_after_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("skid stage filled without a held output word");

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid stage full while output register empty");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
      (rsp_data.src_col == '0 && rsp_data.src_row == '0))
      else $error("nonzero fetch address on a failed word");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg_ff.lens_radius == '0) |-> rsp_data.status == ST_OUTSIDE)
      else $error("zero lens radius must flag every pixel outside");
`endif

endmodule

### tb/sv/fremap_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fremap_scoreboard
// Watches the req, rsp and csr ports of the fisheye remap coordinate
// generator. It keeps its own copy of the lens and image registers, works out
// the source fetch for every accepted req word and compares it, in order,
// with every accepted rsp word.
// ----------------------------------------------------------------------------

module fremap_scoreboard (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  fremap_pkg::req_type              req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  fremap_pkg::rsp_type              rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fremap_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   input  logic                             csr_pready,
   output int                               fail_count,
   output int                               pending
);
   import fremap_pkg::*;

   localparam longint unsigned ATAN_Q30 [24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127};

   cfg_type lens_cfg;
   rsp_type fetch_q [$];

   // floor(sqrt(s) * 2^F), bit-serial root
   function automatic longint unsigned radius_q(input longint unsigned s);
      longint unsigned root, rem, pair, trial;
      root = 0;
      rem  = 0;
      for (int p = COORD_BITS + FRAC_BITS - 1; p >= 0; p--) begin
         pair = 0;
         if (p >= FRAC_BITS) pair = (s >> (2 * (p - FRAC_BITS))) & 3;
         rem   = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint trunc_zero(input longint v);
      if (v >= 0) return v >>> FRAC_BITS;
      return -((-v) >>> FRAC_BITS);
   endfunction

   function automatic rsp_type remap_fetch(input req_type q, input cfg_type c);
      longint unsigned qmax, ax, ay, s, r, theta, tanq, k;
      longint x, y, cx, cy, z, sx, sy, a, dx, dy, vc, vr;
      rsp_type o;
      qmax = (64'd1 << QW) - 1;
      x  = longint'(q.out_col) - longint'(c.out_width / 2);
      y  = longint'(c.out_height / 2) - longint'(q.out_row);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      s  = ax * ax + ay * ay;
      r  = c.lens_radius;
      o  = '0;
      if (s >= r * r) begin
         o.status = ST_OUTSIDE;
         return o;
      end
      theta = ((radius_q(s) / r) * (HALFPI_Q30 >> (30 - FRAC_BITS))) >> FRAC_BITS;
      cx = 64'sd1 <<< FRAC_BITS;
      cy = 0;
      z  = theta;
      for (int i = 0; i < FRAC_BITS; i++) begin
         sx = cy >>> i;
         sy = cx >>> i;
         a  = ATAN_Q30[i] >> (30 - FRAC_BITS);
         if (z >= 0) begin
            cx = cx - sx; cy = cy + sy; z = z - a;
         end else begin
            cx = cx + sx; cy = cy - sy; z = z + a;
         end
      end
      if (cx <= 0) tanq = qmax;
      else if (cy <= 0) tanq = 0;
      else begin
         tanq = (longint'(cy) << FRAC_BITS) / longint'(cx);
         if (tanq > qmax) tanq = qmax;
      end
      if (theta == 0) k = 64'd1 << FRAC_BITS;
      else begin
         k = (tanq << FRAC_BITS) / theta;
         if (k > qmax) k = qmax;
      end
      dx = ax * k;
      if (x < 0) dx = -dx;
      dy = ay * k;
      if (y < 0) dy = -dy;
      vc = trunc_zero((longint'(c.src_width / 2) <<< FRAC_BITS) + dx);
      vr = trunc_zero((longint'(c.src_height / 2) <<< FRAC_BITS) - dy);
      if (vc < 0 || vc >= c.src_width || vr < 0 || vr >= c.src_height) begin
         o.status = ST_OFFIMG;
         return o;
      end
      o.src_col = vc[COORD_BITS-1:0];
      o.src_row = vr[COORD_BITS-1:0];
      o.status  = ST_OK;
      return o;
   endfunction

   assign pending = fetch_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         lens_cfg   <= CFG_RESET;
         fail_count <= 0;
         fetch_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[ADDR_BITS-1:2])
               REG_LENS_RADIUS: lens_cfg.lens_radius <= csr_pwdata[COORD_BITS-1:0];
               REG_OUT_WIDTH:   lens_cfg.out_width   <= csr_pwdata[COORD_BITS-1:0];
               REG_OUT_HEIGHT:  lens_cfg.out_height  <= csr_pwdata[COORD_BITS-1:0];
               REG_SRC_WIDTH:   lens_cfg.src_width   <= csr_pwdata[COORD_BITS-1:0];
               REG_SRC_HEIGHT:  lens_cfg.src_height  <= csr_pwdata[COORD_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            fetch_q.push_back(remap_fetch(req_data, lens_cfg));
         if (rsp_valid && !rsp_stall) begin
            if (fetch_q.size() == 0) begin
               $display("%0t: rsp word with nothing expected, got %h", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = fetch_q.pop_front();
               if (want.src_col !== rsp_data.src_col || want.src_row !== rsp_data.src_row ||
                   want.status !== rsp_data.status) begin
                  $display("%0t: src_col exp %0d got %0d, src_row exp %0d got %0d, status exp %0d got %0d",
                           $realtime, want.src_col, rsp_data.src_col, want.src_row,
                           rsp_data.src_row, want.status, rsp_data.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### tb/sv/tb_fisheye_remap_coordinate_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fisheye_remap_coordinate_gen
// Drives pixel coordinates through the remap generator under several lens
// and image settings with random gaps and back-pressure; a scoreboard
// checks every fetch address and status.
// ----------------------------------------------------------------------------

module tb_fisheye_remap_coordinate_gen;
   import fremap_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [ADDR_BITS-1:0] csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;
   int                   fail_count;
   int                   pending;
   int                   idle_cycles;
   int                   rsp_seen;
   bit                   burst_mode;
   cfg_type              cur_cfg;

   fisheye_remap_coordinate_gen dut (.*);

   fremap_scoreboard scoreboard (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall per word, one long hold-off after 20 words so
   // the pipe fills up and stalls the sender
   initial begin
      int n;
      rsp_stall <= 1'b0;
      rsp_seen  = 0;
      @(negedge reset);
      forever begin
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (rsp_seen == 20) n = 2000;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         rsp_seen++;
      end
   end

   task automatic send_pixel(input int row, input int col);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{out_row: row[COORD_BITS-1:0], out_col: col[COORD_BITS-1:0]};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [IDX_BITS-1:0] idx, input int unsigned value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // upper bits random: only the low 12 are kept
   task automatic load_cfg(input cfg_type c);
      int unsigned hi;
      hi = $urandom() & 32'hffff_f000;
      csr_write(REG_LENS_RADIUS, hi | c.lens_radius);
      csr_write(REG_OUT_WIDTH, hi | c.out_width);
      csr_write(REG_OUT_HEIGHT, hi | c.out_height);
      csr_write(REG_SRC_WIDTH, hi | c.src_width);
      csr_write(REG_SRC_HEIGHT, hi | c.src_height);
      cur_cfg = c;
   endtask

   task automatic random_pixels(input int count);
      int row, col, cr, cc, r;
      cr = cur_cfg.out_height / 2;
      cc = cur_cfg.out_width / 2;
      r  = cur_cfg.lens_radius;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0, 1: begin
               row = $urandom_range(0, cur_cfg.out_height);
               col = $urandom_range(0, cur_cfg.out_width);
            end
            2: begin
               // near the lens rim
               row = cr + $urandom_range(0, r + 2) * (($urandom_range(0, 1)) ? 1 : -1);
               col = cc + $urandom_range(0, 3) - 1;
               if ($urandom_range(0, 1)) begin
                  int t;
                  t = row - cr;
                  row = cr + col - cc;
                  col = cc + t;
               end
            end
            default: begin
               row = $urandom_range(0, 4095);
               col = $urandom_range(0, 4095);
            end
         endcase
         send_pixel(row < 0 ? 0 : row, col < 0 ? 0 : col);
      end
      burst_mode = 0;
   endtask

   initial begin
      cfg_type c;
      int cr, cc;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      burst_mode  = 0;
      cur_cfg     = CFG_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, centre, rim, beyond output size
      cr = cur_cfg.out_height / 2;
      cc = cur_cfg.out_width / 2;
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(0, 4095);
      send_pixel(4095, 0);
      send_pixel(cr, cc);
      send_pixel(cr + 1, cc);
      send_pixel(cr, cc - 1);
      send_pixel(cr - 799, cc);
      send_pixel(cr, cc + 799);
      send_pixel(cr, cc + 800);
      send_pixel(cr + 565, cc + 565);
      send_pixel(cr - 500, cc - 600);
      send_pixel(2048, 2048);
      drain();
      // an unmapped register index must be ignored
      csr_write(IDX_BITS'(5), 32'd7);
      csr_write(IDX_BITS'(7), 32'd7);
      send_pixel(cr, cc);
      send_pixel(cr + 300, cc - 300);
      random_pixels(200);

      // sender pause until every result is back
      drain();
      random_pixels(20);
      drain();

      c = '{lens_radius: 4095, out_width: 4095, out_height: 4095,
            src_width: 4095, src_height: 4095};
      load_cfg(c);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(2047, 2047);
      random_pixels(100);
      drain();

      c = '{lens_radius: 1, out_width: 2, out_height: 2, src_width: 2, src_height: 2};
      load_cfg(c);
      send_pixel(1, 1);
      send_pixel(0, 0);
      random_pixels(60);
      drain();

      // zero radius: all pixels outside
      c.lens_radius = 0;
      c.out_width   = 640;
      c.out_height  = 480;
      load_cfg(c);
      send_pixel(240, 320);
      random_pixels(40);
      drain();

      c = '{lens_radius: 300, out_width: 640, out_height: 480,
            src_width: 200, src_height: 100};
      load_cfg(c);
      random_pixels(100);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         c.lens_radius = $urandom_range(0, 4095);
         c.out_width   = $urandom_range(0, 4095);
         c.out_height  = $urandom_range(0, 4095);
         c.src_width   = $urandom_range(0, 4095);
         c.src_height  = $urandom_range(0, 4095);
         load_cfg(c);
         random_pixels(55);
         drain();
      end

      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
hdl/fremap_pkg.sv
hdl/fremap_root.sv
hdl/fremap_angle.sv
hdl/fremap_ratio.sv
hdl/fremap_out.sv
hdl/fisheye_remap_coordinate_gen.sv
tb/sv/fremap_scoreboard.sv
tb/sv/tb_fisheye_remap_coordinate_gen.sv
